@@ design/ddft_pkg.sv @@
// shared types, constants and twiddle table for the direct dft engine
package ddft_pkg;

	localparam int ROM_LOG2     = 6;
	localparam int TW_W         = 16;
	localparam int OUT_W        = 23;
	localparam int OUT_MAX      = 4194303;
	localparam int OUT_MIN      = -4194304;
	localparam int FRAC_SHIFT   = 15;
	localparam int DRAIN_CYCLES = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;
	localparam int LOG2_W       = 3;
	localparam int COUNT_W      = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALID_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 2'd2;

	localparam logic [LOG2_W-1:0]  LOG2_RESET    = 3'd6;
	localparam logic [COUNT_W-1:0] COUNT_RESET   = 7'd64;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} ddft_state_t;

	typedef struct packed {
		logic wr;
		logic issue;
		logic first;
		logic use_smp;
		logic emit;
		logic last;
	} ddft_cmd_t;

	typedef struct packed {
		logic out_free;
	} ddft_status_t;

	// quarter wave of cosine, q1.15, cos 0 saturated
	localparam logic signed [TW_W-1:0] QCOS [17] = '{
		16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
		16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
		16'sd12540, 16'sd9512, 16'sd6393, 16'sd3212, 16'sd0
	};

	function automatic logic signed [TW_W-1:0] tw_cos(input logic [ROM_LOG2-1:0] m);
		logic signed [TW_W-1:0] v;
		if (m <= 6'd16) begin
			v = QCOS[m[4:0]];
		end else if (m <= 6'd32) begin
			v = -QCOS[5'(6'd32 - m)];
		end else if (m <= 6'd48) begin
			v = -QCOS[5'(m - 6'd32)];
		end else begin
			v = QCOS[5'(7'd64 - {1'b0, m})];
		end
		return v;
	endfunction

	// sine is cosine a quarter turn late
	function automatic logic signed [TW_W-1:0] tw_sin(input logic [ROM_LOG2-1:0] m);
		return tw_cos(m + 6'd48);
	endfunction

endpackage

@@ design/direct_dft_engine.sv @@
// top level of the direct dft engine: configuration registers and unit wiring
//
//   port group   dir   handshake              payload
//   cfg          in    cfg_wr_en              cfg_index, cfg_data
//   sample       in    in_valid / in_ready    sample_real, sample_imag
//   bin          out   out_valid / out_ready  bin_real, bin_imag, bin_index, last_bin
//
// samples load one per cycle; the beat that completes the load starts the transform
// each bin runs N mac issues, a drain and an emit on the shared complex mac,
// so a full transform is N bin passes in a row and no sample is taken meanwhile
// a bin waiting on out_ready stalls the next emit only; mac work continues up to it
// reset clears control and configuration; the sample store is not cleared
module direct_dft_engine import ddft_pkg::*; #(
	parameter int MAX_POINTS  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_real,
	input  logic signed [SAMPLE_BITS-1:0] sample_imag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       bin_real,
	output logic signed [OUT_W-1:0]       bin_imag,
	output logic [5:0]                    bin_index,
	output logic                          last_bin
);

	localparam int AW       = $clog2(MAX_POINTS);
	localparam int MAX_LOG2 = $clog2(MAX_POINTS + 1) - 1;

	logic [LOG2_W-1:0]  log2_length_q;
	logic [COUNT_W-1:0] valid_count_q;
	logic               inverse_mode_q;
	logic [LOG2_W-1:0]  log2_eff;
	logic [COUNT_W-1:0] npts;
	logic [AW-1:0]      nmax;
	logic [COUNT_W-1:0] target;
	ddft_cmd_t          cmd;
	ddft_status_t       status;
	logic [AW-1:0]      wr_addr, rd_addr, k_index;
	logic [ROM_LOG2-1:0] phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_length_q  <= LOG2_RESET;
			valid_count_q  <= COUNT_RESET;
			inverse_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LOG2_LENGTH:  log2_length_q  <= cfg_data[LOG2_W-1:0];
				CFG_VALID_COUNT:  valid_count_q  <= cfg_data;
				CFG_INVERSE_MODE: inverse_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// length clamps to 2..64 and to the store size
	always_comb begin
		log2_eff = log2_length_q;
		if (log2_eff < 3'd1) log2_eff = 3'd1;
		if (log2_eff > 3'(ROM_LOG2)) log2_eff = 3'(ROM_LOG2);
		if (log2_eff > 3'(MAX_LOG2)) log2_eff = 3'(MAX_LOG2);
		npts   = 7'd1 << log2_eff;
		nmax   = AW'(npts - 7'd1);
		target = (valid_count_q < npts) ? valid_count_q : npts;
		if (target == '0) target = 7'd1;
	end

	ddft_ctrl #(
		.AW (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.nmax        (nmax),
		.target      (target),
		.valid_count (valid_count_q),
		.log2_eff    (log2_eff),
		.status      (status),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.phase       (phase),
		.k_index     (k_index)
	);

	ddft_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW),
		.DEPTH       (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.phase       (phase),
		.k_index     (k_index),
		.log2_eff    (log2_eff),
		.inverse     (inverse_mode_q),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bin_real    (bin_real),
		.bin_imag    (bin_imag),
		.bin_index   (bin_index),
		.last_bin    (last_bin)
	);

endmodule

@@ design/ddft_ram.sv @@
// generic single write port ram with registered read
module ddft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/ddft_ctrl.sv @@
// sequencer: load counting, bin and sample counters, phase and pipeline drain
module ddft_ctrl import ddft_pkg::*; #(
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [AW-1:0]      nmax,
	input  logic [COUNT_W-1:0] target,
	input  logic [COUNT_W-1:0] valid_count,
	input  logic [LOG2_W-1:0]  log2_eff,
	input  ddft_status_t       status,
	output ddft_cmd_t          cmd,
	output logic [AW-1:0]      wr_addr,
	output logic [AW-1:0]      rd_addr,
	output logic [ROM_LOG2-1:0] phase,
	output logic [AW-1:0]      k_index
);

	ddft_state_t state_q, state_d;
	logic [AW-1:0]       load_cnt_q;
	logic [AW-1:0]       n_q;
	logic [AW-1:0]       k_q;
	logic [ROM_LOG2-1:0] phase_q;
	logic [1:0]          drain_q;
	logic                in_fire;
	logic                more;
	logic                n_last;
	logic                k_last;
	logic                drain_done;
	logic [ROM_LOG2-1:0] step;

	assign in_fire    = in_valid && (state_q == ST_LOAD);
	assign more       = (COUNT_W'(load_cnt_q) + 7'd1) < target;
	assign n_last     = (n_q == nmax);
	assign k_last     = (k_q == nmax);
	assign drain_done = (drain_q == 2'(DRAIN_CYCLES - 1));
	// angle step of bin k in rom units
	assign step       = ROM_LOG2'(k_q) << (LOG2_W'(ROM_LOG2) - log2_eff);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && !more) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (n_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_d = k_last ? ST_LOAD : ST_MAC;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_LOAD);
		cmd.wr      = in_fire;
		cmd.issue   = (state_q == ST_MAC);
		cmd.first   = (n_q == '0);
		cmd.use_smp = COUNT_W'(n_q) < valid_count;
		cmd.emit    = (state_q == ST_EMIT) && status.out_free;
		cmd.last    = k_last;
		wr_addr     = load_cnt_q;
		rd_addr     = n_q;
		phase       = phase_q;
		k_index     = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			n_q        <= '0;
			k_q        <= '0;
			phase_q    <= '0;
			drain_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						load_cnt_q <= more ? load_cnt_q + 1'b1 : '0;
						n_q        <= '0;
						k_q        <= '0;
						phase_q    <= '0;
					end
				end
				ST_MAC: begin
					phase_q <= phase_q + step;
					drain_q <= '0;
					n_q     <= n_last ? '0 : n_q + 1'b1;
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						k_q     <= k_q + 1'b1;
						phase_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ design/ddft_datapath.sv @@
// sample store, twiddle lookup, complex mac, rounding and output register
module ddft_datapath import ddft_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int AW          = 6,
	parameter int DEPTH       = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ddft_cmd_t                     cmd,
	output ddft_status_t                  status,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [ROM_LOG2-1:0]           phase,
	input  logic [AW-1:0]                 k_index,
	input  logic [LOG2_W-1:0]             log2_eff,
	input  logic                          inverse,
	input  logic signed [SAMPLE_BITS-1:0] sample_real,
	input  logic signed [SAMPLE_BITS-1:0] sample_imag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       bin_real,
	output logic signed [OUT_W-1:0]       bin_imag,
	output logic [5:0]                    bin_index,
	output logic                          last_bin
);

	localparam int PROD_W = SAMPLE_BITS + TW_W;
	localparam int ACC_W  = PROD_W + AW + 2;

	logic [2*SAMPLE_BITS-1:0]      rd_data;
	logic signed [SAMPLE_BITS-1:0] xr, xi;
	logic signed [TW_W-1:0]        sin_raw;
	logic                          issue_s1, first_s1, use_s1;
	logic signed [TW_W-1:0]        cos_s1, sin_s1;
	logic                          issue_s2, first_s2;
	logic signed [PROD_W-1:0]      rc_s2, is_s2, ic_s2, rs_s2;
	logic signed [ACC_W-1:0]       acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0]       base_re, base_im;
	logic [4:0]                    shift;
	logic                          out_valid_q;

	function automatic logic signed [OUT_W-1:0] round_sat(
		input logic signed [ACC_W-1:0] v,
		input logic [4:0]              sh
	);
		logic signed [ACC_W:0] t;
		logic signed [ACC_W:0] hi;
		logic signed [ACC_W:0] lo;
		hi = (ACC_W+1)'(OUT_MAX);
		lo = (ACC_W+1)'(OUT_MIN);
		t  = {v[ACC_W-1], v} + ((ACC_W+1)'(1) << (sh - 5'd1));
		t  = t >>> sh;
		if (t > hi) t = hi;
		if (t < lo) t = lo;
		return t[OUT_W-1:0];
	endfunction

	ddft_ram #(
		.WIDTH (2*SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.wr),
		.wr_addr (wr_addr),
		.wr_data ({sample_imag, sample_real}),
		.rd_en   (cmd.issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// padded positions feed zero into the products
	assign xr      = use_s1 ? $signed(rd_data[SAMPLE_BITS-1:0]) : '0;
	assign xi      = use_s1 ? $signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
	assign sin_raw = tw_sin(phase);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			issue_s2 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			issue_s2 <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		use_s1   <= cmd.use_smp;
		cos_s1   <= tw_cos(phase);
		sin_s1   <= inverse ? -sin_raw : sin_raw;
		first_s2 <= first_s1;
		rc_s2    <= xr * cos_s1;
		is_s2    <= xi * sin_s1;
		ic_s2    <= xi * cos_s1;
		rs_s2    <= xr * sin_s1;
	end

	assign base_re = first_s2 ? '0 : acc_re_q;
	assign base_im = first_s2 ? '0 : acc_im_q;

	always_ff @(posedge clk) begin
		if (issue_s2) begin
			acc_re_q <= base_re + ACC_W'(rc_s2) + ACC_W'(is_s2);
			acc_im_q <= base_im + ACC_W'(ic_s2) - ACC_W'(rs_s2);
		end
	end

	// inverse adds log2 n to the rounding shift
	assign shift = 5'(FRAC_SHIFT) + (inverse ? 5'(log2_eff) : 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bin_real  <= round_sat(acc_re_q, shift);
			bin_imag  <= round_sat(acc_im_q, shift);
			bin_index <= 6'(k_index);
			last_bin  <= cmd.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

@@ design/ddft_checker.sv @@
// port level checks for the direct dft engine and their binding
module ddft_checker import ddft_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] bin_real,
	input logic signed [OUT_W-1:0] bin_imag,
	input logic [5:0]              bin_index,
	input logic                    last_bin
);

	// a stalled bin beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_real) && $stable(bin_imag)
			&& $stable(bin_index) && $stable(last_bin))
		else $error("bin beat changed while stalled");

	// sample ready drops only on the beat that completes a load
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready fell without an accepted sample");

	// a pending bin that is not the last means the transform is still running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_bin |-> !in_ready)
		else $error("samples accepted while a transform is in progress");

	// bins are at least a mac pass apart, so back to back beats drain the register
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 (out_valid && out_ready) |=> !out_valid)
		else $error("bins emitted faster than the mac can produce them");

endmodule

bind direct_dft_engine ddft_checker u_ddft_checker (.*);
